[design/amgt_pkg.sv]
`timescale 1ns / 1ps

package amgt_pkg;

   // Field widths fixed by the item format
   localparam int FUNC_W   = 2;
   localparam int VERTEX_W = 4;
   localparam int CNT_W    = 5;

   localparam int MAX_VERTICES_DEFAULT = 16;
   localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;

   // APB register map
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_VERTEX_COUNT_ADDR = 2'd0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD_EDGE    = 2'd0,
      FUNC_REMOVE_EDGE = 2'd1,
      FUNC_BFS         = 2'd2,
      FUNC_DFS         = 2'd3
   } amgt_func_type;

   typedef enum logic [1:0] {
      EMIT_STATUS    = 2'd0,
      EMIT_PEND      = 2'd1,
      EMIT_PEND_LAST = 2'd2
   } amgt_emit_type;

   typedef struct packed {
      logic          idle;
      logic          edge_write;
      logic          trav_init;
      logic          bfs_pop;
      logic          bfs_scan;
      logic          dfs_load;
      logic          dfs_push;
      logic          dfs_pop;
      logic          scan_skip;
      logic          emit;
      amgt_emit_type emit_kind;
   } amgt_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic is_edge;
      logic is_bfs;
      logic range_err;
      logic out_free;
      logic scan_done;
      logic hit;
      logic queue_empty;
      logic stack_empty;
      logic pend_valid;
   } amgt_sts_type;

endpackage

[design/amgt_ifs.sv]
`timescale 1ns / 1ps

interface amgt_req_if;
   logic                          valid;
   logic                          ready;
   logic [amgt_pkg::FUNC_W-1:0]   func;
   logic [amgt_pkg::VERTEX_W-1:0] from_vertex;
   logic [amgt_pkg::VERTEX_W-1:0] to_vertex;

   modport source (output valid, output func, output from_vertex, output to_vertex,
                   input ready);
   modport sink (input valid, input func, input from_vertex, input to_vertex,
                 output ready);
endinterface

interface amgt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [amgt_pkg::VERTEX_W-1:0] vertex;
   logic                          last;
   logic                          status;

   modport source (output valid, output vertex, output last, output status,
                   input ready);
   modport sink (input valid, input vertex, input last, input status,
                 output ready);
endinterface

[design/amgt_ctrl.sv]
`timescale 1ns / 1ps

module amgt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  amgt_pkg::amgt_sts_type sts,
   output amgt_pkg::amgt_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_BFS_POP,
      S_BFS_SCAN,
      S_DFS_LOAD,
      S_DFS_SCAN,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd           = '0;
      cmd.emit_kind = amgt_pkg::EMIT_STATUS;
      state_in      = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.idle = 1'b1;
            if (sts.req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_edge || sts.range_err) begin
               // single status result
               if (sts.out_free) begin
                  cmd.emit       = 1'b1;
                  cmd.edge_write = sts.is_edge;
                  cmd.trav_init  = !sts.is_edge;
                  state_in       = S_IDLE;
               end
            end else begin
               cmd.trav_init = 1'b1;
               state_in      = sts.is_bfs ? S_BFS_POP : S_DFS_LOAD;
            end
         end
         S_BFS_POP: begin
            if (sts.queue_empty) begin
               state_in = S_FINISH;
            end else if (!sts.pend_valid || sts.out_free) begin
               cmd.bfs_pop   = 1'b1;
               cmd.emit      = sts.pend_valid;
               cmd.emit_kind = amgt_pkg::EMIT_PEND;
               state_in      = S_BFS_SCAN;
            end
         end
         S_BFS_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_BFS_POP;
            end else begin
               cmd.bfs_scan = 1'b1;
            end
         end
         S_DFS_LOAD: begin
            if (sts.stack_empty) begin
               state_in = S_FINISH;
            end else begin
               cmd.dfs_load = 1'b1;
               state_in     = S_DFS_SCAN;
            end
         end
         S_DFS_SCAN: begin
            if (sts.scan_done) begin
               cmd.dfs_pop = 1'b1;
               state_in    = S_DFS_LOAD;
            end else if (sts.hit) begin
               if (sts.out_free) begin
                  cmd.dfs_push  = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = amgt_pkg::EMIT_PEND;
               end
            end else begin
               cmd.scan_skip = 1'b1;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = amgt_pkg::EMIT_PEND_LAST;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/amgt_dp.sv]
`timescale 1ns / 1ps

module amgt_dp #(
   parameter int MAX_VERTICES = amgt_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [amgt_pkg::CNT_W-1:0]      vertex_count,
   input  amgt_pkg::amgt_cmd_type          cmd,
   output amgt_pkg::amgt_sts_type          sts,
   amgt_req_if.sink                        req,
   amgt_rsp_if.source                      rsp
);

   localparam int VCAP  = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
   localparam int IDX_W = $clog2(VCAP);
   localparam int PTR_W = $clog2(VCAP + 1);
   localparam int VW    = amgt_pkg::VERTEX_W;
   localparam int CW    = amgt_pkg::CNT_W;

   // control state
   logic [VCAP-1:0]  adj_ff [VCAP];
   logic [VCAP-1:0]  adj_in [VCAP];
   logic [VCAP-1:0]  visited_ff, visited_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic             pend_valid_ff, pend_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload
   logic [amgt_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [VW-1:0]    from_ff, from_in;
   logic [VW-1:0]    to_ff, to_in;
   logic [VW-1:0]    cur_v_ff, cur_v_in;
   logic [PTR_W-1:0] scan_ff, scan_in;
   logic [VW-1:0]    pend_ff, pend_in;
   logic [VW-1:0]    wl_ff [VCAP];
   logic [VW-1:0]    wl_in [VCAP];
   logic [PTR_W-1:0] sp_ff [VCAP];
   logic [PTR_W-1:0] sp_in [VCAP];
   logic [VW-1:0]    rsp_vertex_ff, rsp_vertex_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_status_ff, rsp_status_in;

   logic [CW-1:0]    n_cmp;
   logic [IDX_W-1:0] from_idx, to_idx, cur_idx, scan_idx, head_idx, tail_idx, top_idx;
   logic             load_req, is_edge, is_bfs, range_err, out_free, hit;

   // effective vertex count: zero acts as one, clipped to the storage limit
   always_comb begin
      if (vertex_count == '0) begin
         n_cmp = CW'(1);
      end else if (vertex_count > CW'(VCAP)) begin
         n_cmp = CW'(VCAP);
      end else begin
         n_cmp = vertex_count;
      end
   end

   assign from_idx = from_ff[IDX_W-1:0];
   assign to_idx   = to_ff[IDX_W-1:0];
   assign cur_idx  = cur_v_ff[IDX_W-1:0];
   assign scan_idx = scan_ff[IDX_W-1:0];
   assign head_idx = head_ff[IDX_W-1:0];
   assign tail_idx = tail_ff[IDX_W-1:0];
   assign top_idx  = IDX_W'(tail_ff - 1'b1);

   assign is_edge   = (func_ff == amgt_pkg::FUNC_ADD_EDGE) ||
                      (func_ff == amgt_pkg::FUNC_REMOVE_EDGE);
   assign is_bfs    = (func_ff == amgt_pkg::FUNC_BFS);
   assign range_err = (CW'(from_ff) >= n_cmp) || (is_edge && (CW'(to_ff) >= n_cmp));
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign hit       = adj_ff[cur_idx][scan_idx] && !visited_ff[scan_idx];
   assign load_req  = cmd.idle && req.valid;

   assign req.ready = cmd.idle;

   always_comb begin
      sts.req_valid   = req.valid;
      sts.is_edge     = is_edge;
      sts.is_bfs      = is_bfs;
      sts.range_err   = range_err;
      sts.out_free    = out_free;
      sts.scan_done   = CW'(scan_ff) >= n_cmp;
      sts.hit         = hit;
      sts.queue_empty = head_ff == tail_ff;
      sts.stack_empty = tail_ff == '0;
      sts.pend_valid  = pend_valid_ff;
   end

   always_comb begin
      adj_in        = adj_ff;
      visited_in    = visited_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      pend_valid_in = pend_valid_ff;
      func_in       = func_ff;
      from_in       = from_ff;
      to_in         = to_ff;
      cur_v_in      = cur_v_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      wl_in         = wl_ff;
      sp_in         = sp_ff;

      if (load_req) begin
         func_in = req.func;
         from_in = req.from_vertex;
         to_in   = req.to_vertex;
      end
      if (cmd.edge_write && !range_err) begin
         adj_in[from_idx][to_idx] = (func_ff == amgt_pkg::FUNC_ADD_EDGE);
      end
      if (cmd.trav_init) begin
         visited_in = '0;
         if (!range_err) begin
            visited_in[from_idx] = 1'b1;
         end
         head_in       = '0;
         tail_in       = PTR_W'(1);
         wl_in[0]      = from_ff;
         sp_in[0]      = '0;
         pend_in       = from_ff;
         pend_valid_in = !is_bfs;
      end
      if (cmd.bfs_pop) begin
         cur_v_in      = wl_ff[head_idx];
         pend_in       = wl_ff[head_idx];
         pend_valid_in = 1'b1;
         head_in       = head_ff + 1'b1;
         scan_in       = '0;
      end
      if (cmd.bfs_scan) begin
         scan_in = scan_ff + 1'b1;
         if (hit) begin
            visited_in[scan_idx] = 1'b1;
            wl_in[tail_idx]      = VW'(scan_ff);
            tail_in              = tail_ff + 1'b1;
         end
      end
      if (cmd.dfs_load) begin
         cur_v_in = wl_ff[top_idx];
         scan_in  = sp_ff[top_idx];
      end
      if (cmd.scan_skip) begin
         scan_in = scan_ff + 1'b1;
      end
      if (cmd.dfs_push) begin
         // resume point for the current level, then descend
         sp_in[top_idx]       = scan_ff + 1'b1;
         wl_in[tail_idx]      = VW'(scan_ff);
         sp_in[tail_idx]      = '0;
         tail_in              = tail_ff + 1'b1;
         visited_in[scan_idx] = 1'b1;
         pend_in              = VW'(scan_ff);
         cur_v_in             = VW'(scan_ff);
         scan_in              = '0;
      end
      if (cmd.dfs_pop) begin
         tail_in = tail_ff - 1'b1;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         unique case (cmd.emit_kind)
            amgt_pkg::EMIT_STATUS: begin
               rsp_vertex_in = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = range_err;
            end
            amgt_pkg::EMIT_PEND: begin
               rsp_vertex_in = pend_ff;
               rsp_last_in   = 1'b0;
               rsp_status_in = 1'b0;
            end
            amgt_pkg::EMIT_PEND_LAST: begin
               rsp_vertex_in = pend_ff;
               rsp_last_in   = 1'b1;
               rsp_status_in = 1'b0;
            end
            default: begin
               rsp_vertex_in = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = 1'b1;
            end
         endcase
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.vertex = rsp_vertex_ff;
   assign rsp.last   = rsp_last_ff;
   assign rsp.status = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < VCAP; r++) begin
            adj_ff[r] <= '0;
         end
         visited_ff    <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         adj_ff        <= adj_in;
         visited_ff    <= visited_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      from_ff       <= from_in;
      to_ff         <= to_in;
      cur_v_ff      <= cur_v_in;
      scan_ff       <= scan_in;
      pend_ff       <= pend_in;
      wl_ff         <= wl_in;
      sp_ff         <= sp_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

`ifndef SYNTHESIS
   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= PTR_W'(VCAP))
      else $error("work list overflow");

   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("queue head passed tail");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result emitted into a full output register");

   a_push_unvisited: assert property (@(posedge clock) disable iff (reset)
      cmd.dfs_push |-> !visited_ff[scan_idx])
      else $error("depth-first push of a visited vertex");
`endif

endmodule

[design/adjacency_matrix_graph_traversal_core.sv]
`timescale 1ns / 1ps

// Directed graph engine on an adjacency bit matrix with BFS / DFS walks.
// req: one transfer per operation (func, from_vertex, to_vertex); taken only
//   while the core is idle, one operation at a time.
// rsp: add/remove edge gives one transfer (vertex 0, last 1, status 1 when a
//   vertex is not below the vertex count). A traversal gives every reachable
//   vertex in visiting order, last set on the final one; a bad start vertex
//   gives a single status-1 transfer instead.
// APB register 0 (byte 0): vertex_count, 5 bits, reset 16; 0 acts as 1 and
//   values above the vertex limit act as the limit. Write only while idle.
// Timing: an edge operation's request is registered and decoded, and its
//   result enters the output register once that register is free.
//   A traversal scans one matrix bit per cycle, but a depth-first scan holds
//   at a found vertex while the output register is full; each visited vertex
//   is taken from the BFS queue or DFS stack, then its row is scanned.
// Stalls: results sit in one output register; while rsp is stalled the walk
//   holds at its next result (BFS pop, DFS hit, final one) until it drains.
// Reset (synchronous): clears all edges, visited map, list pointers and the
//   output valid flag; vertex_count returns to 16.
module adjacency_matrix_graph_traversal_core #(
   parameter int MAX_VERTICES = amgt_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   amgt_req_if.sink                          req,
   amgt_rsp_if.source                        rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [amgt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [amgt_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [amgt_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   logic [amgt_pkg::CNT_W-1:0] vertex_count_ff, vertex_count_in;
   logic                       csr_hit;
   amgt_pkg::amgt_cmd_type     cmd;
   amgt_pkg::amgt_sts_type     sts;

   // APB: zero wait states, write lands in the access phase
   assign pready  = 1'b1;
   assign csr_hit = (paddr == amgt_pkg::CSR_VERTEX_COUNT_ADDR);

   always_comb begin
      vertex_count_in = vertex_count_ff;
      if (psel && penable && pwrite && csr_hit) begin
         vertex_count_in = pwdata[amgt_pkg::CNT_W-1:0];
      end
   end

   // unmapped addresses read as zero
   assign prdata = csr_hit ? amgt_pkg::CSR_DATA_W'(vertex_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= amgt_pkg::VERTEX_COUNT_RESET;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   // sequencer: walks BFS queue / DFS stack, paces the output register
   amgt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // matrix, visited map, work list, scan pointers and result register
   amgt_dp #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .vertex_count (vertex_count_ff),
      .cmd          (cmd),
      .sts          (sts),
      .req          (req),
      .rsp          (rsp)
   );

endmodule
